// ----- design/sphop_pkg.sv -----
// ----------------------------------------------------------------------------
// sphop_pkg
// widths, pipeline depth and the stage record of the sphere overlap and
// push-apart pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package sphop_pkg;

    localparam int COORD_W = 32;
    localparam int DW      = COORD_W + 1;
    localparam int SQW     = 2 * DW;
    localparam int LW      = DW + 1;
    localparam int QW      = COORD_W + 2;
    localparam int NW      = DW + COORD_W;
    localparam int RMW     = LW + 3;
    localparam int DRW     = LW + 1;
    localparam int VW      = QW + 1;
    localparam int NST     = 5 + LW + QW;
    localparam int IN_W    = 8 * ((6 * COORD_W + 2 * (COORD_W - 1) + 7) / 8);
    localparam int OUT_W   = 8 * ((3 * COORD_W + 7) / 8);

    typedef struct packed {
        logic                      cmd;
        logic                      hit;
        logic                      moved;
        logic [2:0]                neg;
        logic [2:0][COORD_W-1:0]   a;
        logic [2:0][COORD_W-1:0]   b;
        logic [COORD_W-1:0]        rs;
        logic [2:0][DW-1:0]        m;
        logic [2:0][SQW-1:0]       sq;
        logic [SQW-1:0]            s;
        logic [2:0][NW-1:0]        num;
        logic [2*LW-1:0]           rad;
        logic [RMW-1:0]            srem;
        logic [LW-1:0]             root;
        logic [2:0][DRW-1:0]       drem;
        logic [2:0][QW-1:0]        dlo;
    } t_pipe;

endpackage
`default_nettype wire

// ----- design/sphere_overlap_and_push_apart_top.sv -----
// ----------------------------------------------------------------------------
// sphere_overlap_and_push_apart_top
// sphere pair overlap test with push-apart of sphere a along the centre line
// ----------------------------------------------------------------------------
// pipeline: a one-bit-per-stage square root (34 stages), a restoring divider
// (34 stages) and five capture, difference, product, compare and saturate stages
// throughput: one request per cycle while the output is not stalled, every stage takes a new request each cycle
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset: synchronous active-low, clears all stage valid bits
`default_nettype none
module sphere_overlap_and_push_apart_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
    input  wire logic [sphop_pkg::IN_W-1:0]  i_s_axis_tdata,
    // command
    input  wire logic                        i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // new_a_x, new_a_y, new_a_z
    output logic [sphop_pkg::OUT_W-1:0]      o_m_axis_tdata,
    // hit, moved
    output logic [1:0]                       o_m_axis_tuser
);
    import sphop_pkg::*;

    localparam int CW = COORD_W;

    logic [NST-1:0] r_vld;
    t_pipe          r_p [NST];
    t_pipe          n_p [NST];
    logic           w_en;
    logic           w_acc;

    assign w_en            = !r_vld[NST-1] || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;

    always_comb begin
        logic [DW-1:0]     d;
        logic [SQW-1:0]    dsum;
        logic [RMW-1:0]    rr;
        logic [RMW-1:0]    trial;
        logic [DRW:0]      t;
        logic [DRW:0]      lx;
        logic [VW-1:0]     be;
        logic [VW-1:0]     qe;
        logic [VW-1:0]     v;
        n_p[0] = r_p[0];
        for (int k = 1; k < NST; k++) begin
            n_p[k] = r_p[k-1];
        end
        // input capture
        n_p[0].cmd = i_s_axis_tuser;
        for (int i = 0; i < 3; i++) begin
            n_p[0].a[i] = i_s_axis_tdata[i*CW +: CW];
            n_p[0].b[i] = i_s_axis_tdata[3*CW + CW - 1 + i*CW +: CW];
        end
        n_p[0].rs = {1'b0, i_s_axis_tdata[3*CW +: CW-1]}
                  + {1'b0, i_s_axis_tdata[6*CW + CW - 1 +: CW-1]};
        // difference and magnitude
        for (int i = 0; i < 3; i++) begin
            d = {r_p[0].a[i][CW-1], r_p[0].a[i]} - {r_p[0].b[i][CW-1], r_p[0].b[i]};
            n_p[1].neg[i] = d[DW-1];
            n_p[1].m[i]   = d[DW-1] ? (~d + DW'(1)) : d;
        end
        // products
        for (int i = 0; i < 3; i++) begin
            n_p[2].sq[i]  = r_p[1].m[i] * r_p[1].m[i];
            n_p[2].num[i] = r_p[1].m[i] * r_p[1].rs;
        end
        n_p[2].s = r_p[1].rs * r_p[1].rs;
        // distance compare, root and divider setup
        dsum = r_p[2].sq[0] + r_p[2].sq[1] + r_p[2].sq[2];
        n_p[3].hit   = (dsum <= r_p[2].s);
        n_p[3].moved = (dsum <= r_p[2].s) && r_p[2].cmd
                     && ((|r_p[2].m[0]) || (|r_p[2].m[1]) || (|r_p[2].m[2]));
        n_p[3].rad   = {{(2*LW-SQW){1'b0}}, dsum};
        n_p[3].srem  = '0;
        n_p[3].root  = '0;
        for (int i = 0; i < 3; i++) begin
            n_p[3].drem[i] = {{(DRW-(NW-QW)){1'b0}}, r_p[2].num[i][NW-1:QW]};
            n_p[3].dlo[i]  = r_p[2].num[i][QW-1:0];
        end
        // square root, one result bit per stage
        for (int k = 4; k < 4 + LW; k++) begin
            rr    = {r_p[k-1].srem[RMW-3:0], r_p[k-1].rad[2*LW-1 -: 2]};
            trial = {1'b0, r_p[k-1].root, 2'b01};
            n_p[k].rad = {r_p[k-1].rad[2*LW-3:0], 2'b00};
            if (rr >= trial) begin
                n_p[k].srem = rr - trial;
                n_p[k].root = {r_p[k-1].root[LW-2:0], 1'b1};
            end else begin
                n_p[k].srem = rr;
                n_p[k].root = {r_p[k-1].root[LW-2:0], 1'b0};
            end
        end
        // restoring divide by the root, one quotient bit per stage
        for (int k = 4 + LW; k < 4 + LW + QW; k++) begin
            for (int i = 0; i < 3; i++) begin
                t  = {r_p[k-1].drem[i], r_p[k-1].dlo[i][QW-1]};
                lx = {{(DRW+1-LW){1'b0}}, r_p[k-1].root};
                if (t >= lx) begin
                    n_p[k].drem[i] = DRW'(t - lx);
                    n_p[k].dlo[i]  = {r_p[k-1].dlo[i][QW-2:0], 1'b1};
                end else begin
                    n_p[k].drem[i] = t[DRW-1:0];
                    n_p[k].dlo[i]  = {r_p[k-1].dlo[i][QW-2:0], 1'b0};
                end
            end
        end
        // offset from b and saturate
        for (int i = 0; i < 3; i++) begin
            be = {{(VW-CW){r_p[NST-2].b[i][CW-1]}}, r_p[NST-2].b[i]};
            qe = {1'b0, r_p[NST-2].dlo[i]};
            v  = r_p[NST-2].neg[i] ? (be - qe) : (be + qe);
            if (r_p[NST-2].moved) begin
                if (!v[VW-1] && (|v[VW-2:CW-1])) begin
                    n_p[NST-1].a[i] = {1'b0, {(CW-1){1'b1}}};
                end else if (v[VW-1] && !(&v[VW-2:CW-1])) begin
                    n_p[NST-1].a[i] = {1'b1, {(CW-1){1'b0}}};
                end else begin
                    n_p[NST-1].a[i] = v[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NST; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {r_p[NST-1].a[2], r_p[NST-1].a[1], r_p[NST-1].a[0]};
    assign o_m_axis_tuser  = {r_p[NST-1].moved, r_p[NST-1].hit};

endmodule
`default_nettype wire

// ----- design/sphop_chk.sv -----
// ----------------------------------------------------------------------------
// sphop_chk
// port-level checks for the sphere overlap and push-apart block
// ----------------------------------------------------------------------------
`default_nettype none
module sphop_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_s_axis_tready,
    input  wire logic                        o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    input  wire logic [sphop_pkg::OUT_W-1:0] o_m_axis_tdata,
    input  wire logic [1:0]                  o_m_axis_tuser
);
    // input side ready follows the output slot
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output slot");

    // a moved result always reports a hit
    a_moved_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser[1] || o_m_axis_tuser[0]))
        else $error("moved without hit");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sphere_overlap_and_push_apart_top sphop_chk u_chk (.*);
`default_nettype wire

// ----- dv/tb_sphere_overlap_and_push_apart_top.sv -----
// ----------------------------------------------------------------------------
// tb_sphere_overlap_and_push_apart_top
// streams sphere pairs through the overlap and push-apart pipeline, predicts
// hit, moved and the new centre of sphere a with exact wide arithmetic and
// compares every result in order, under random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_sphere_overlap_and_push_apart_top;
    import sphop_pkg::*;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] ax, ay, az;
        logic        [30:0] ar;
        logic signed [31:0] bx, by, bz;
        logic        [30:0] br;
    } t_pair;

    typedef struct packed {
        logic               hit;
        logic               moved;
        logic signed [31:0] nx, ny, nz;
    } t_push;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_W-1:0] s_data = '0;
    logic s_user = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;
    logic [1:0] m_user;

    t_pair pair_q[$];
    t_push push_q[$];
    int errors = 0;
    int n_hits = 0, n_moved = 0, n_results = 0;
    bit quiet = 1'b0;
    bit feeding = 1'b1;
    int hold_off = 0;
    int s_gap = 0, m_gap = 0;
    int idle_cycles = 0;

    sphere_overlap_and_push_apart_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(logic [131:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({68'd0, c} * {68'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_push push_apart(t_pair p);
        t_push o;
        logic signed [33:0] a[3], b[3], d[3];
        logic [33:0] m[3];
        logic [131:0] dist2, lim, num, q;
        logic [63:0] len;
        logic [32:0] rs;
        logic signed [67:0] v;
        logic signed [31:0] res[3];
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
        rs = {2'b0, p.ar} + {2'b0, p.br};
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = a[i] - b[i];
            m[i] = d[i] < 0 ? -d[i] : d[i];
            dist2 += {98'd0, m[i]} * {98'd0, m[i]};
        end
        lim = {99'd0, rs} * {99'd0, rs};
        o.hit = dist2 <= lim;
        o.moved = o.hit && p.cmd && (m[0] | m[1] | m[2]) != 0;
        for (int i = 0; i < 3; i++) begin
            res[i] = a[i][31:0];
            if (o.moved) begin
                len = isqrt(dist2);
                num = {98'd0, m[i]} * {99'd0, rs};
                q = num / {68'd0, len};
                v = d[i] < 0 ? 68'(b[i]) - $signed({1'b0, q[66:0]})
                             : 68'(b[i]) + $signed({1'b0, q[66:0]});
                if (v > 68'sd2147483647) v = 68'sd2147483647;
                if (v < -68'sd2147483648) v = -68'sd2147483648;
                res[i] = v[31:0];
            end
        end
        o.nx = res[0]; o.ny = res[1]; o.nz = res[2];
        return o;
    endfunction

    function automatic logic [31:0] rnd_coord(int sel);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_pair(t_pair p);
        pair_q.push_back(p);
    endtask

    // mostly places sphere b near a so overlaps are common, else anywhere
    task automatic add_random;
        t_pair p;
        int sc;
        sc = $urandom_range(0, 9);
        p.cmd = $urandom_range(0, 3) != 0;
        p.ax = rnd_coord($urandom_range(0, 6) == 0 ? $urandom_range(0, 3) : 2 + sc % 2);
        p.ay = rnd_coord($urandom_range(0, 6) == 0 ? $urandom_range(0, 3) : 2 + sc % 2);
        p.az = rnd_coord($urandom_range(0, 6) == 0 ? $urandom_range(0, 3) : 2 + sc % 2);
        if (sc < 7) begin
            p.bx = p.ax + 32'($signed($urandom_range(0, 2 << sc * 3)) - (1 << sc * 3));
            p.by = p.ay + 32'($signed($urandom_range(0, 2 << sc * 3)) - (1 << sc * 3));
            p.bz = p.az + 32'($signed($urandom_range(0, 2 << sc * 3)) - (1 << sc * 3));
            p.ar = 31'($urandom_range(0, 2 << sc * 3));
            p.br = 31'($urandom_range(0, 2 << sc * 3));
        end else begin
            p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
            p.ar = 31'($urandom); p.br = 31'($urandom);
        end
        if ($urandom_range(0, 30) == 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
        end
        add_pair(p);
    endtask

    initial begin
        t_pair p;
        // extremes, coincident centres, detect only, touching, far apart
        p = '{1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff};
        add_pair(p);
        p.cmd = 1'b0; add_pair(p);
        p = '{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff};
        add_pair(p);
        p = '{1'b1, 32'sd5, 32'sd5, 32'sd5, 31'd3, 32'sd5, 32'sd5, 32'sd5, 31'd3};
        add_pair(p);
        p = '{1'b1, 32'sd0, 32'sd0, 32'sd0, 31'd0, 32'sd0, 32'sd0, 32'sd0, 31'd0};
        add_pair(p);
        p = '{1'b1, 32'sd3, 32'sd4, 32'sd0, 31'd2, 32'sd0, 32'sd0, 32'sd0, 31'd3};
        add_pair(p);
        p = '{1'b1, 32'sd3, 32'sd4, 32'sd0, 31'd2, 32'sd0, 32'sd0, 32'sd0, 31'd2};
        add_pair(p);
        p = '{1'b0, 32'sd1, 32'sd1, 32'sd1, 31'd100, 32'sd0, 32'sd0, 32'sd0, 31'd100};
        add_pair(p);
        p = '{1'b1, 32'sh7ffffff0, 32'sd0, 32'sd0, 31'h7fffffff,
              32'sh7fffff00, 32'sd0, 32'sd0, 31'd0};
        add_pair(p);
        p = '{1'b1, -32'sd1, -32'sd1, -32'sd1, 31'h10000, 32'sd0, 32'sd0, 32'sd0, 31'h10000};
        add_pair(p);
        p = '{1'b1, 32'sh80000000, 32'sd0, 32'sd0, 31'h7fffffff,
              32'sh80000010, 32'sd0, 32'sd0, 31'h7fffffff};
        add_pair(p);
        for (int i = 0; i < 1440; i++) add_random();
        wait (pair_q.size() == 0 && !s_valid);
        feeding = 1'b0;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pair_q.size() > 0) begin
                    t_pair p;
                    p = pair_q.pop_front();
                    push_q.push_back(push_apart(p));
                    s_valid <= 1'b1;
                    s_user <= p.cmd;
                    s_data <= {2'b00, p.br, p.bz, p.by, p.bx, p.ar, p.az, p.ay, p.ax};
                    if (!quiet && $urandom_range(0, 7) == 0) s_gap <= $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                t_push e;
                idle_cycles <= 0;
                if (push_q.size() == 0) begin
                    $display("%0t unexpected request result tdata=%h tuser=%b",
                             $realtime, m_data, m_user);
                    errors++;
                end else begin
                    e = push_q.pop_front();
                    n_results++;
                    n_hits += e.hit;
                    n_moved += e.moved;
                    if ({m_user[0], m_user[1]} != {e.hit, e.moved}) begin
                        $display("%0t hit/moved expected %b%b actual %b%b", $realtime,
                                 e.hit, e.moved, m_user[0], m_user[1]);
                        errors++;
                    end
                    if (m_data[95:0] != {e.nz, e.ny, e.nx}) begin
                        $display("%0t new_a expected %h actual %h", $realtime,
                                 {e.nz, e.ny, e.nx}, m_data[95:0]);
                        errors++;
                    end
                end
            end else if (!(s_valid && s_ready)) begin
                idle_cycles <= idle_cycles + 1;
            end else begin
                idle_cycles <= 0;
            end
            if (n_results == 400 && hold_off == 0 && m_ready) begin
                hold_off <= 300;
                m_ready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
            end else if (hold_off == 1) begin
                hold_off <= -1;
                m_ready <= 1'b1;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= m_gap == 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_gap <= $urandom_range(1, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if (n_results > 1300) quiet <= 1'b1;
        end
    end

    initial begin
        wait (i_rst_n);
        wait (!feeding && push_q.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("covered %0d sphere pairs: %0d hits, %0d pushed apart",
                 n_results, n_hits, n_moved);
        if (errors == 0 && push_q.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        wait (i_rst_n);
        wait (idle_cycles >= 2000);
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
